/* rtl/smhq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smhq_pkg: shared types and constants of the split/merge qualifier
// Field widths, register indexes, layout modes and the stage-1 geometry record.
// ----------------------------------------------------------------------------
package smhq_pkg;

  // Coordinate and counter sizing
  localparam int COORD_BITS = 24;
  localparam int COUNT_BITS = 16;

  // Fixed field widths
  localparam int DIST_W     = 23;
  localparam int DELAY_W    = 16;
  localparam int BIAS_W     = 16;
  localparam int OUT_CNT_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;
  localparam int BIAS_FRAC  = 8;

  // Derived arithmetic widths
  localparam int MAG_W      = COORD_BITS;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int DSUM_W     = SQ_W + 1;
  localparam int THR_SQ_W   = 2 * DIST_W;
  localparam int CMP_D_W    = (DSUM_W > THR_SQ_W) ? DSUM_W : THR_SQ_W;
  localparam int PROD_W     = MAG_W + BIAS_W;
  localparam int CNT_CMP_W  = (COUNT_BITS > DELAY_W) ? COUNT_BITS : DELAY_W;

  // Register reset values
  localparam logic [DIST_W-1:0]  SPLIT_DIST_RST  = DIST_W'(4096);
  localparam logic [DIST_W-1:0]  MERGE_DIST_RST  = DIST_W'(2560);
  localparam logic [DELAY_W-1:0] SPLIT_DELAY_RST = DELAY_W'(30);
  localparam logic [DELAY_W-1:0] MERGE_DELAY_RST = DELAY_W'(60);
  localparam logic [BIAS_W-1:0]  BIAS_RST        = BIAS_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPLIT_DIST  = 3'd0,
    REG_MERGE_DIST  = 3'd1,
    REG_SPLIT_DELAY = 3'd2,
    REG_MERGE_DELAY = 3'd3,
    REG_BIAS        = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_SINGLE = 2'd0,
    MODE_HSPLIT = 2'd1,
    MODE_VSPLIT = 2'd2
  } mode_e;

  // Squares and orientation operands of one transaction
  typedef struct packed {
    logic              clear;
    logic [SQ_W-1:0]   sq_x;
    logic [SQ_W-1:0]   sq_y;
    logic [MAG_W-1:0]  ady;
    logic [PROD_W-1:0] adx_bias;
  } geo_t;

  typedef struct packed {
    mode_e                mode;
    logic                 changed;
    logic [OUT_CNT_W-1:0] split_count;
    logic [OUT_CNT_W-1:0] merge_count;
  } result_t;

endpackage

/* rtl/smhq_prep.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smhq_prep: planar offset, magnitudes and products
// Forms dx and dy on the selected plane, squares them and scales |dx| by bias.
// ----------------------------------------------------------------------------
module smhq_prep import smhq_pkg::*; (
  input  logic                         func_i,
  input  logic signed [COORD_BITS-1:0] a_x_i,
  input  logic signed [COORD_BITS-1:0] a_y_i,
  input  logic signed [COORD_BITS-1:0] a_z_i,
  input  logic signed [COORD_BITS-1:0] b_x_i,
  input  logic signed [COORD_BITS-1:0] b_y_i,
  input  logic signed [COORD_BITS-1:0] b_z_i,
  input  logic                         plane_xz_i,
  input  logic        [BIAS_W-1:0]     bias_i,
  output geo_t                         geo_o
);

  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic signed [COORD_BITS:0] dx_abs;
  logic signed [COORD_BITS:0] dy_abs;
  logic        [MAG_W-1:0]    adx;
  logic        [MAG_W-1:0]    ady;

  always_comb begin
    dx = (COORD_BITS+1)'(b_x_i) - (COORD_BITS+1)'(a_x_i);
    if (plane_xz_i) begin
      dy = (COORD_BITS+1)'(b_z_i) - (COORD_BITS+1)'(a_z_i);
    end else begin
      dy = (COORD_BITS+1)'(b_y_i) - (COORD_BITS+1)'(a_y_i);
    end
    dx_abs = dx[COORD_BITS] ? -dx : dx;
    dy_abs = dy[COORD_BITS] ? -dy : dy;
    adx    = dx_abs[MAG_W-1:0];
    ady    = dy_abs[MAG_W-1:0];

    geo_o.clear    = func_i;
    geo_o.sq_x     = SQ_W'(adx) * SQ_W'(adx);
    geo_o.sq_y     = SQ_W'(ady) * SQ_W'(ady);
    geo_o.ady      = ady;
    geo_o.adx_bias = PROD_W'(adx) * PROD_W'(bias_i);
  end

endmodule

/* rtl/smhq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smhq_ctrl: layout mode and dwell counters
// Compares distance against thresholds and steps the hysteresis state.
// ----------------------------------------------------------------------------
module smhq_ctrl import smhq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  geo_t                geo_i,
  input  logic [THR_SQ_W-1:0] split_sq_i,
  input  logic [THR_SQ_W-1:0] merge_sq_i,
  input  logic [DELAY_W-1:0]  split_delay_i,
  input  logic [DELAY_W-1:0]  merge_delay_i,
  output result_t             result_o
);

  mode_e                 mode_q, mode_d;
  logic                  changed_q, changed_d;
  logic [COUNT_BITS-1:0] split_q, split_d;
  logic [COUNT_BITS-1:0] merge_q, merge_d;

  logic [DSUM_W-1:0]     dist_sq;
  logic                  far;
  logic                  near;
  logic                  tall;
  logic [COUNT_BITS-1:0] split_inc;
  logic [COUNT_BITS-1:0] merge_inc;
  logic [CNT_CMP_W-1:0]  split_ext;
  logic [CNT_CMP_W-1:0]  merge_ext;

  always_comb begin
    dist_sq   = DSUM_W'(geo_i.sq_x) + DSUM_W'(geo_i.sq_y);
    far       = CMP_D_W'(dist_sq) >= CMP_D_W'(split_sq_i);
    near      = CMP_D_W'(dist_sq) <= CMP_D_W'(merge_sq_i);
    tall      = PROD_W'({geo_i.ady, {BIAS_FRAC{1'b0}}}) > geo_i.adx_bias;
    // saturate, never wrap
    split_inc = (&split_q) ? split_q : split_q + COUNT_BITS'(1);
    merge_inc = (&merge_q) ? merge_q : merge_q + COUNT_BITS'(1);

    mode_d    = mode_q;
    changed_d = 1'b0;
    split_d   = split_q;
    merge_d   = merge_q;

    if (geo_i.clear) begin
      mode_d  = MODE_SINGLE;
      split_d = '0;
      merge_d = '0;
    end else if (mode_q == MODE_SINGLE) begin
      merge_d = '0;
      if (!far) begin
        split_d = '0;
      end else if (CNT_CMP_W'(split_inc) >= CNT_CMP_W'(split_delay_i)) begin
        mode_d    = tall ? MODE_HSPLIT : MODE_VSPLIT;
        split_d   = '0;
        changed_d = 1'b1;
      end else begin
        split_d = split_inc;
      end
    end else begin
      split_d = '0;
      if (!near) begin
        merge_d = '0;
      end else if (CNT_CMP_W'(merge_inc) >= CNT_CMP_W'(merge_delay_i)) begin
        mode_d    = MODE_SINGLE;
        merge_d   = '0;
        changed_d = 1'b1;
      end else begin
        merge_d = merge_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_SINGLE;
      changed_q <= 1'b0;
      split_q   <= '0;
      merge_q   <= '0;
    end else if (step_i) begin
      mode_q    <= mode_d;
      changed_q <= changed_d;
      split_q   <= split_d;
      merge_q   <= merge_d;
    end
  end

  always_comb begin
    split_ext            = CNT_CMP_W'(split_q);
    merge_ext            = CNT_CMP_W'(merge_q);
    result_o.mode        = mode_q;
    result_o.changed     = changed_q;
    result_o.split_count = split_ext[OUT_CNT_W-1:0];
    result_o.merge_count = merge_ext[OUT_CNT_W-1:0];
  end

endmodule

/* rtl/split_merge_hysteresis_qualifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// split_merge_hysteresis_qualifier: split-screen layout qualifier
// Two-stage pipeline that qualifies split and merge decisions with dwell time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one tick: func_i, both
//   player positions and the plane select. Output channel (out_valid_o /
//   out_stall_i) returns one result transaction per input transaction, in
//   order: mode, mode_changed, split_count and merge_count.
//   Stage 1 registers the squared offsets and the bias product (one
//   24x24 multiplier per axis, one 24x16 for orientation). Stage 2 sums,
//   compares and steps the mode/counter state; its registers are the result.
//   An accepted transaction is registered in stage 1, then in stage 2, before
//   out_valid_o rises; throughput is one transaction per cycle unless stalled.
//   The configuration port writes one register per cycle at cfg_we_i; write
//   it only while no transaction is in flight. Threshold squares are
//   re-registered every cycle and settle in the cycle after a write.
//   Reset loads the register defaults, sets single mode and zero counters
//   and empties both stages. While out_stall_i holds a result, stage 1
//   still takes one more transaction before in_stall_o rises.
// ----------------------------------------------------------------------------
module split_merge_hysteresis_qualifier import smhq_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic        [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic        [CFG_DATA_W-1:0] cfg_data_i,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         func_i,
  input  logic signed [COORD_BITS-1:0] a_x_i,
  input  logic signed [COORD_BITS-1:0] a_y_i,
  input  logic signed [COORD_BITS-1:0] a_z_i,
  input  logic signed [COORD_BITS-1:0] b_x_i,
  input  logic signed [COORD_BITS-1:0] b_y_i,
  input  logic signed [COORD_BITS-1:0] b_z_i,
  input  logic                         plane_xz_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic        [1:0]            mode_o,
  output logic                         mode_changed_o,
  output logic        [OUT_CNT_W-1:0]  split_count_o,
  output logic        [OUT_CNT_W-1:0]  merge_count_o
);

  // Configuration registers
  logic [DIST_W-1:0]   split_dist_q;
  logic [DIST_W-1:0]   merge_dist_q;
  logic [DELAY_W-1:0]  split_delay_q;
  logic [DELAY_W-1:0]  merge_delay_q;
  logic [BIAS_W-1:0]   bias_q;
  logic [THR_SQ_W-1:0] split_sq_q;
  logic [THR_SQ_W-1:0] merge_sq_q;

  // Pipeline control
  logic    s1_valid_q, s1_valid_d;
  logic    out_valid_q, out_valid_d;
  logic    s1_load;
  logic    out_load;
  geo_t    geo;
  geo_t    s1_q;
  result_t result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_dist_q  <= SPLIT_DIST_RST;
      merge_dist_q  <= MERGE_DIST_RST;
      split_delay_q <= SPLIT_DELAY_RST;
      merge_delay_q <= MERGE_DELAY_RST;
      bias_q        <= BIAS_RST;
    end else if (cfg_we_i) begin
      // keep only the register's own width; drop unknown indexes
      unique case (cfg_index_i)
        REG_SPLIT_DIST:  split_dist_q  <= cfg_data_i[DIST_W-1:0];
        REG_MERGE_DIST:  merge_dist_q  <= cfg_data_i[DIST_W-1:0];
        REG_SPLIT_DELAY: split_delay_q <= cfg_data_i[DELAY_W-1:0];
        REG_MERGE_DELAY: merge_delay_q <= cfg_data_i[DELAY_W-1:0];
        REG_BIAS:        bias_q        <= cfg_data_i[BIAS_W-1:0];
        default: ;
      endcase
    end
  end

  // Square the thresholds once per cycle so the compare needs no multiplier
  always_ff @(posedge clk_i) begin
    split_sq_q <= THR_SQ_W'(split_dist_q) * THR_SQ_W'(split_dist_q);
    merge_sq_q <= THR_SQ_W'(merge_dist_q) * THR_SQ_W'(merge_dist_q);
  end

  // Advance stage 1 into the result register whenever the result slot is
  // free or being taken this cycle; hold stage 1 otherwise.
  always_comb begin
    out_load    = s1_valid_q && (!out_valid_q || !out_stall_i);
    in_stall_o  = s1_valid_q && !out_load;
    s1_load     = in_valid_i && !in_stall_o;
    s1_valid_d  = s1_load || (s1_valid_q && !out_load);
    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  smhq_prep u_prep (
    .func_i     (func_i),
    .a_x_i      (a_x_i),
    .a_y_i      (a_y_i),
    .a_z_i      (a_z_i),
    .b_x_i      (b_x_i),
    .b_y_i      (b_y_i),
    .b_z_i      (b_z_i),
    .plane_xz_i (plane_xz_i),
    .bias_i     (bias_q),
    .geo_o      (geo)
  );

  // Stage 1 payload: products of the accepted transaction
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_q <= geo;
    end
  end

  smhq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (out_load),
    .geo_i         (s1_q),
    .split_sq_i    (split_sq_q),
    .merge_sq_i    (merge_sq_q),
    .split_delay_i (split_delay_q),
    .merge_delay_i (merge_delay_q),
    .result_o      (result)
  );

  assign out_valid_o    = out_valid_q;
  assign mode_o         = result.mode;
  assign mode_changed_o = result.changed;
  assign split_count_o  = result.split_count;
  assign merge_count_o  = result.merge_count;

endmodule

/* rtl/smhq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smhq_checker: port-level checks of the split/merge qualifier
// Watches the output channel for handshake and mode/counter consistency.
// ----------------------------------------------------------------------------
module smhq_checker import smhq_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [1:0]           mode_o,
  input logic                 mode_changed_o,
  input logic [OUT_CNT_W-1:0] split_count_o,
  input logic [OUT_CNT_W-1:0] merge_count_o
);

  // A stalled result stays offered and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mode_o) &&
      $stable(mode_changed_o) && $stable(split_count_o) && $stable(merge_count_o))
    else $error("result changed while stalled");

  // A mode switch restarts both dwell counters
  a_switch_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_changed_o |-> split_count_o == '0 && merge_count_o == '0)
    else $error("counter not cleared on mode change");

  // Single mode never counts toward a merge
  a_single_no_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_o == MODE_SINGLE |-> merge_count_o == '0)
    else $error("merge count in single mode");

  // Split modes never count toward a split
  a_split_no_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_o == MODE_HSPLIT || mode_o == MODE_VSPLIT) |->
      split_count_o == '0)
    else $error("split count in split mode");

endmodule

bind split_merge_hysteresis_qualifier smhq_checker u_smhq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .mode_o         (mode_o),
  .mode_changed_o (mode_changed_o),
  .split_count_o  (split_count_o),
  .merge_count_o  (merge_count_o)
);

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: split/merge layout qualifier check
// Drives position ticks and clear transactions through the qualifier with
// random idle and stall bursts. Predicts the layout mode and both dwell
// counters per transaction and checks every result field in order. Walks the
// register settings through defaults, extremes and random values.
// ----------------------------------------------------------------------------
module testbench;
  import smhq_pkg::*;

  localparam int CLK_HALF   = 2;
  localparam int CYCLE_CAP  = 1000000;
  localparam int COORD_MAX  = 2 ** (COORD_BITS - 1) - 1;
  localparam int COORD_MIN  = -(2 ** (COORD_BITS - 1));
  localparam int SPAN_FULL  = 2 ** COORD_BITS - 1;
  localparam int DIST_MAX   = 2 ** DIST_W - 1;
  localparam int DELAY_MAX  = 2 ** DELAY_W - 1;
  localparam int DRAIN_WAIT = 6;
  localparam int LONG_DWELL = 40;

  // Indexes past the last register; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // How far apart the two players are relative to the thresholds
  typedef enum int {SPAN_FAR, SPAN_NEAR, SPAN_MID} span_e;

  typedef struct {
    logic                         func;
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] a_z;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] b_z;
    logic                         plane_xz;
  } tick_t;

  typedef struct {
    mode_e                mode;
    logic                 changed;
    logic [OUT_CNT_W-1:0] split_count;
    logic [OUT_CNT_W-1:0] merge_count;
  } layout_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  in_valid    = 1'b0;
  logic                  out_stall   = 1'b0;
  tick_t                 cur_tick    = '{default: '0};
  logic                  in_stall;
  logic                  out_valid;
  logic [1:0]            mode;
  logic                  mode_changed;
  logic [OUT_CNT_W-1:0]  split_count;
  logic [OUT_CNT_W-1:0]  merge_count;

  // Stimulus and expectation stores
  tick_t   pending_ticks[$];
  layout_t expected_layouts[$];

  // Predicted block state and register copies
  mode_e                layout_q      = MODE_SINGLE;
  logic [OUT_CNT_W-1:0] split_ticks_q = '0;
  logic [OUT_CNT_W-1:0] merge_ticks_q = '0;
  logic [DIST_W-1:0]    split_dist_q  = SPLIT_DIST_RST;
  logic [DIST_W-1:0]    merge_dist_q  = MERGE_DIST_RST;
  logic [DELAY_W-1:0]   split_delay_q = SPLIT_DELAY_RST;
  logic [DELAY_W-1:0]   merge_delay_q = MERGE_DELAY_RST;
  logic [BIAS_W-1:0]    bias_q        = BIAS_RST;

  int      errors      = 0;
  int      cycle_count = 0;
  int      gap_left    = 0;
  int      stall_left  = 0;
  bit      quiet       = 1'b0;
  layout_t seen_want;

  split_merge_hysteresis_qualifier dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (cur_tick.func),
    .a_x_i          (cur_tick.a_x),
    .a_y_i          (cur_tick.a_y),
    .a_z_i          (cur_tick.a_z),
    .b_x_i          (cur_tick.b_x),
    .b_y_i          (cur_tick.b_y),
    .b_z_i          (cur_tick.b_z),
    .plane_xz_i     (cur_tick.plane_xz),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .mode_o         (mode),
    .mode_changed_o (mode_changed),
    .split_count_o  (split_count),
    .merge_count_o  (merge_count)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Append one transaction to the stimulus store
  function automatic void queue_tick(input tick_t t);
    pending_ticks.insert(pending_ticks.size(), t);
  endfunction

  // Append one prediction to the expectation store
  function automatic void expect_layout(input layout_t r);
    expected_layouts.insert(expected_layouts.size(), r);
  endfunction

  // Saturate a dwell counter instead of wrapping
  function automatic logic [OUT_CNT_W-1:0] bump_count(input logic [OUT_CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // Step the layout state by one accepted transaction and return its result
  function automatic layout_t advance_layout(input tick_t t);
    longint            dx, dy;
    longint unsigned   adx, ady, dist_sq, split_sq, merge_sq;
    layout_t           r;
    r.changed = 1'b0;
    if (t.func) begin
      layout_q      = MODE_SINGLE;
      split_ticks_q = '0;
      merge_ticks_q = '0;
    end else begin
      dx = longint'(t.b_x) - longint'(t.a_x);
      dy = t.plane_xz ? longint'(t.b_z) - longint'(t.a_z)
                      : longint'(t.b_y) - longint'(t.a_y);
      adx      = (dx < 0) ? -dx : dx;
      ady      = (dy < 0) ? -dy : dy;
      dist_sq  = adx * adx + ady * ady;
      split_sq = longint'(split_dist_q) * longint'(split_dist_q);
      merge_sq = longint'(merge_dist_q) * longint'(merge_dist_q);
      if (layout_q == MODE_SINGLE) begin
        merge_ticks_q = '0;
        if (dist_sq >= split_sq) begin
          split_ticks_q = bump_count(split_ticks_q);
          if (split_ticks_q >= split_delay_q) begin
            // Orientation is exact: |dy| * 1.0 against |dx| * bias in Q8.8
            layout_q      = (ady * 256 > adx * longint'(bias_q)) ? MODE_HSPLIT : MODE_VSPLIT;
            split_ticks_q = '0;
            r.changed     = 1'b1;
          end
        end else begin
          split_ticks_q = '0;
        end
      end else begin
        split_ticks_q = '0;
        if (dist_sq <= merge_sq) begin
          merge_ticks_q = bump_count(merge_ticks_q);
          if (merge_ticks_q >= merge_delay_q) begin
            layout_q      = MODE_SINGLE;
            merge_ticks_q = '0;
            r.changed     = 1'b1;
          end
        end else begin
          merge_ticks_q = '0;
        end
      end
    end
    r.mode        = layout_q;
    r.split_count = split_ticks_q;
    r.merge_count = merge_ticks_q;
    return r;
  endfunction

  // Place two coordinates on one axis so that b - a equals the offset
  function automatic void place_pair(input int offset, output int a, output int b);
    int lo, hi;
    lo = (offset < 0) ? COORD_MIN - offset : COORD_MIN;
    hi = (offset > 0) ? COORD_MAX - offset : COORD_MAX;
    a  = lo + int'($urandom_range(0, hi - lo));
    b  = a + offset;
  endfunction

  // Random positions and plane; func picks update or clear
  function automatic tick_t make_noise(input bit func);
    tick_t t;
    t.func     = func;
    t.a_x      = COORD_BITS'($urandom);
    t.a_y      = COORD_BITS'($urandom);
    t.a_z      = COORD_BITS'($urandom);
    t.b_x      = COORD_BITS'($urandom);
    t.b_y      = COORD_BITS'($urandom);
    t.b_z      = COORD_BITS'($urandom);
    t.plane_xz = 1'($urandom_range(0, 1));
    return t;
  endfunction

  // Update transaction whose planar distance lands in the given band
  function automatic tick_t make_tick(input span_e span);
    tick_t       t;
    int unsigned along, across, ftmp;
    int          off_x, off_y, a, b;
    t = make_noise(1'b0);
    case (span)
      SPAN_FAR: begin
        if ($urandom_range(0, 1)) begin
          ftmp  = split_dist_q + $urandom_range(0, 255);
          along = (ftmp > SPAN_FULL) ? SPAN_FULL : ftmp;
        end else begin
          along = $urandom_range(split_dist_q, SPAN_FULL);
        end
        across = $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, SPAN_FULL);
      end
      SPAN_NEAR: begin
        if ($urandom_range(0, 3) == 0) begin
          // Sits exactly on the merge threshold
          along  = merge_dist_q;
          across = 0;
        end else begin
          along  = $urandom_range(0, merge_dist_q / 2);
          across = $urandom_range(0, merge_dist_q / 2);
        end
      end
      default: begin
        along  = $urandom_range(0, split_dist_q);
        across = $urandom_range(0, split_dist_q);
      end
    endcase
    if ($urandom_range(0, 1)) begin
      off_x = int'(along);
      off_y = int'(across);
    end else begin
      off_x = int'(across);
      off_y = int'(along);
    end
    if ($urandom_range(0, 1)) off_x = -off_x;
    if ($urandom_range(0, 1)) off_y = -off_y;
    place_pair(off_x, a, b);
    t.a_x = COORD_BITS'(a);
    t.b_x = COORD_BITS'(b);
    place_pair(off_y, a, b);
    if (t.plane_xz) begin
      t.a_z = COORD_BITS'(a);
      t.b_z = COORD_BITS'(b);
    end else begin
      t.a_y = COORD_BITS'(a);
      t.b_y = COORD_BITS'(b);
    end
    return t;
  endfunction

  task automatic add_update(input int ax, input int ay, input int az,
                            input int bx, input int by, input int bz, input bit plane);
    tick_t t;
    t.func     = 1'b0;
    t.a_x      = COORD_BITS'(ax);
    t.a_y      = COORD_BITS'(ay);
    t.a_z      = COORD_BITS'(az);
    t.b_x      = COORD_BITS'(bx);
    t.b_y      = COORD_BITS'(by);
    t.b_z      = COORD_BITS'(bz);
    t.plane_xz = plane;
    queue_tick(t);
  endtask

  task automatic add_run(input span_e span, input int len);
    repeat (len) queue_tick(make_tick(span));
  endtask

  // Hold until every queued transaction went out and every result came back
  task automatic wait_drain();
    while (pending_ticks.size() != 0 || in_valid || expected_layouts.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[CFG_DATA_W-1:0];
    case (idx)
      REG_SPLIT_DIST:  split_dist_q  = data[DIST_W-1:0];
      REG_MERGE_DIST:  merge_dist_q  = data[DIST_W-1:0];
      REG_SPLIT_DELAY: split_delay_q = data[DELAY_W-1:0];
      REG_MERGE_DELAY: merge_delay_q = data[DELAY_W-1:0];
      REG_BIAS:        bias_q        = data[BIAS_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drain, let the pipeline settle, then load all five registers
  task automatic load_setting(input int unsigned split, input int unsigned merge,
                              input int unsigned sdelay, input int unsigned mdelay,
                              input int unsigned bias);
    wait_drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    write_reg(REG_SPLIT_DIST, split);
    write_reg(REG_MERGE_DIST, merge);
    write_reg(REG_SPLIT_DELAY, sdelay);
    write_reg(REG_MERGE_DELAY, mdelay);
    write_reg(REG_BIAS, bias);
  endtask

  // Mostly dwell runs sized around the delays, some noise, clears and pauses
  task automatic run_phase(input int n_items);
    int    sent, pick, len, base;
    span_e span;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        queue_tick(make_noise(1'b1));
        sent++;
      end else if (pick < 18) begin
        queue_tick(make_noise(1'b0));
        sent++;
      end else if (pick < 20) begin
        wait_drain();
      end else begin
        span = (pick < 60) ? SPAN_FAR : (pick < 90) ? SPAN_NEAR : SPAN_MID;
        base = (span == SPAN_FAR) ? split_delay_q :
               (span == SPAN_NEAR) ? merge_delay_q : 3;
        if (base == 0) base = 1;
        // Short runs break a dwell, exact ones complete it, long ones run past
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, base)
                                          : base - 1 + $urandom_range(0, 2);
        if (len < 1) len = 1;
        add_run(span, len);
        sent += len;
      end
    end
  endtask

  // Driver: advance to the next pending transaction once the current one is taken
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) expect_layout(advance_layout(cur_tick));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          gap_left <= $urandom_range(0, 3);
          in_valid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          cur_tick <= pending_ticks.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each taken result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_layouts.size() == 0) begin
          $display("%0t: result with nothing expected, mode %0d", $time, mode);
          errors++;
        end else begin
          seen_want = expected_layouts.pop_front();
          if (mode !== seen_want.mode) begin
            $display("%0t: mode expected %0d actual %0d", $time, seen_want.mode, mode);
            errors++;
          end
          if (mode_changed !== seen_want.changed) begin
            $display("%0t: mode_changed expected %0d actual %0d", $time, seen_want.changed,
                     mode_changed);
            errors++;
          end
          if (split_count !== seen_want.split_count) begin
            $display("%0t: split_count expected %0d actual %0d", $time, seen_want.split_count,
                     split_count);
            errors++;
          end
          if (merge_count !== seen_want.merge_count) begin
            $display("%0t: merge_count expected %0d actual %0d", $time, seen_want.merge_count,
                     merge_count);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall_left <= $urandom_range(0, 3);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_layouts.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int k;
    int unsigned split, merge;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: a zero split delay acts on the first far tick
    write_reg(REG_SPLIT_DELAY, 0);
    write_reg(REG_MERGE_DELAY, 1);
    add_update(COORD_MIN, 0, 0, COORD_MAX, 0, 0, 1'b0);           // widest dx, vertical
    add_update(7, -3, 9, 7, -3, 9, 1'b0);                         // same spot, merge
    add_update(5, COORD_MAX, COORD_MIN, 5, COORD_MIN, COORD_MAX, 1'b1); // z axis, horizontal
    queue_tick(make_noise(1'b1));                                 // clear while split
    add_update(100, 0, 0, 100 + 4096, 0, 0, 1'b0);                // exactly on split
    add_update(0, 0, 0, 0, -2560, 0, 1'b0);                       // exactly on merge
    add_update(0, 0, 0, 4095, 0, 0, 1'b0);                        // just short of split
    add_update(0, 0, 0, 4096, 4096, 0, 1'b0);                     // orientation tie
    add_update(0, 0, 0, 2561, 0, 0, 1'b0);                        // just beyond merge
    add_update(0, 0, 0, 1, 1, 0, 1'b0);
    add_update(COORD_MAX, COORD_MAX, 0, COORD_MIN, COORD_MIN, 0, 1'b0);
    queue_tick(make_noise(1'b1));
    queue_tick(make_noise(1'b1));                                 // clear while single
    add_update(0, 0, 0, 4096, 0, 4097, 1'b1);                     // dy wins by one
    add_update(0, 0, 0, 0, 0, 0, 1'b1);

    // Delay lowered while counting: the next far tick must switch.
    // The split delay write also carries junk above the register width.
    wait_drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    write_reg(REG_SPLIT_DELAY, 23'h7F000A);
    write_reg(REG_MERGE_DELAY, 8);
    add_run(SPAN_FAR, 5);
    wait_drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    write_reg(REG_SPLIT_DELAY, 3);
    write_reg(REG_SPARE_LO, 1);                                   // dropped
    write_reg(REG_SPARE_HI, DIST_MAX);                            // dropped
    add_run(SPAN_FAR, 1);
    add_run(SPAN_NEAR, 4);
    wait_drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    write_reg(REG_MERGE_DELAY, 2);
    add_run(SPAN_NEAR, 1);

    // Random phases: defaults, both extremes, then random settings
    load_setting(SPLIT_DIST_RST, MERGE_DIST_RST, SPLIT_DELAY_RST, MERGE_DELAY_RST, BIAS_RST);
    run_phase(110);
    load_setting(DIST_MAX, DIST_MAX, 1, 1, DELAY_MAX);
    run_phase(60);
    load_setting(1, 1, 2, 3, 1);
    run_phase(60);
    for (k = 0; k < 5; k++) begin
      case ($urandom_range(0, 2))
        0:       split = $urandom_range(1, 255);
        1:       split = $urandom_range(256, 65535);
        default: split = $urandom_range(1, DIST_MAX);
      endcase
      merge = ($urandom_range(0, 3) != 0) ? $urandom_range(1, split)
                                          : $urandom_range(1, DIST_MAX);
      load_setting(split, merge, $urandom_range(1, 8), $urandom_range(1, 8),
                   $urandom_range(0, 1) ? $urandom_range(1, DELAY_MAX)
                                        : $urandom_range(128, 512));
      run_phase(60);
    end

    // Last part runs without idling: a full split dwell, then a merge
    wait_drain();
    quiet = 1'b1;
    load_setting(3000, 1500, LONG_DWELL, 4, 512);
    add_run(SPAN_FAR, LONG_DWELL);
    add_run(SPAN_NEAR, 6);
    load_setting($urandom_range(1, 20000), $urandom_range(1, 10000), $urandom_range(1, 6),
                 $urandom_range(1, 6), $urandom_range(1, DELAY_MAX));
    run_phase(60);

    wait_drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
